// File: design/tla_pkg.sv
// Shared types, codes and constants for the turn lamp arbiter.
// Used by tla_core and turn_lamp_arbiter_with_status; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tla_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_FRAME_ID     = 2'd0;
	localparam logic [1:0] REG_BLINK_HALF   = 2'd1;
	localparam logic [1:0] REG_STATUS_PER   = 2'd2;

	localparam int CFG_W      = 11;
	localparam int IN_TDATA_W = 24;
	localparam int OUT_TDATA_W = 16;

	localparam logic [10:0] FRAME_ID_RST     = 11'd256;
	localparam logic [9:0]  BLINK_HALF_RST   = 10'd100;
	localparam logic [9:0]  STATUS_PER_RST   = 10'd20;

	// Turn command codes
	localparam logic [1:0] TURN_OFF    = 2'd0;
	localparam logic [1:0] TURN_LEFT   = 2'd1;
	localparam logic [1:0] TURN_RIGHT  = 2'd2;
	localparam logic [1:0] TURN_HAZARD = 2'd3;

	// Active lamp codes
	localparam logic [1:0] LAMP_NONE = 2'd0;
	localparam logic [1:0] LAMP_POS  = 2'd1;
	localparam logic [1:0] LAMP_TURN = 2'd2;

	// Turn status codes in the status frame
	localparam logic [1:0] TSTAT_IDLE = 2'd0;
	localparam logic [1:0] TSTAT_LIT  = 2'd1;
	localparam logic [1:0] TSTAT_DARK = 2'd2;

	typedef struct packed {
		logic        slot_free;
		logic [7:0]  frame_byte;
		logic [10:0] frame_id;
		logic        frame_valid;
		logic        click;
	} item_t;

	typedef struct packed {
		logic [3:0] status_byte1;
		logic [4:0] status_byte0;
		logic       status_sent;
		logic [1:0] active_lamp;
		logic       pos_lamp_on;
		logic       turn_lamp_on;
	} result_t;

	typedef struct packed {
		logic [1:0] turn_cmd;
		logic       pos_cmd;
		logic [9:0] blink_ticks;
		logic       blink_phase;
		logic [9:0] status_ticks;
		logic [3:0] rolling_count;
	} state_t;

	typedef struct packed {
		logic [10:0] frame_id;
		logic [9:0]  blink_half;
		logic [9:0]  status_per;
	} cfg_t;

endpackage

`default_nettype wire

// File: design/tla_core.sv
// Per-tick logic: command update, lamp arbitration and status frame build.
// Purely combinational; depends on tla_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tla_core
	import tla_pkg::*;
(
	input  wire item_t   item,
	input  wire state_t  st,
	input  wire cfg_t    cfg,
	output state_t       st_nxt,
	output result_t      res
);

	logic [1:0] turn;
	logic       pos;
	logic [9:0] bt;
	logic       phase;
	logic [9:0] stt;
	logic       turn_lamp;
	logic       pos_lamp;
	logic [1:0] active;
	logic [1:0] tstat;
	logic       sent;

	always_comb begin
		turn = st.turn_cmd;
		pos  = st.pos_cmd;
		if (item.click) begin
			unique case (st.turn_cmd)
				TURN_OFF:   turn = TURN_RIGHT;
				TURN_RIGHT: turn = TURN_HAZARD;
				default:    turn = TURN_OFF;
			endcase
		end
		// frame applied after the click, so it wins
		if (item.frame_valid && item.frame_id == cfg.frame_id) begin
			turn = item.frame_byte[1:0];
			pos  = item.frame_byte[2];
		end

		if (turn == TURN_RIGHT || turn == TURN_HAZARD) begin
			bt    = st.blink_ticks + 10'd1;
			phase = st.blink_phase;
			if (bt >= cfg.blink_half) begin
				bt    = '0;
				phase = ~phase;
			end
			turn_lamp = phase;
			pos_lamp  = 1'b0;
			active    = LAMP_TURN;
		end else begin
			bt        = '0;
			phase     = 1'b0;
			turn_lamp = 1'b0;
			pos_lamp  = pos;
			active    = pos ? LAMP_POS : LAMP_NONE;
		end

		stt  = st.status_ticks + 10'd1;
		sent = 1'b0;
		if (stt >= cfg.status_per) begin
			stt  = '0;
			sent = item.slot_free;
		end

		if (active == LAMP_TURN) begin
			tstat = turn_lamp ? TSTAT_LIT : TSTAT_DARK;
		end else begin
			tstat = TSTAT_IDLE;
		end

		st_nxt.turn_cmd      = turn;
		st_nxt.pos_cmd       = pos;
		st_nxt.blink_ticks   = bt;
		st_nxt.blink_phase   = phase;
		st_nxt.status_ticks  = stt;
		st_nxt.rolling_count = sent ? st.rolling_count + 4'd1 : st.rolling_count;

		res.turn_lamp_on = turn_lamp;
		res.pos_lamp_on  = pos_lamp;
		res.active_lamp  = active;
		res.status_sent  = sent;
		res.status_byte0 = sent ? {active, pos_lamp, tstat} : 5'd0;
		res.status_byte1 = sent ? st.rolling_count : 4'd0;
	end

endmodule

`default_nettype wire

// File: design/turn_lamp_arbiter_with_status.sv
// Top level of the turn lamp arbiter: stream ports, config registers, tick state.
// Depends on tla_pkg and tla_core.
`timescale 1ns / 1ps
`default_nettype none

// Each input transfer is one service tick and yields exactly one output transfer.
// The block takes one tick every clock cycle while its output is not stalled; a tick
// passes an input register and then a result register, and its result is offered
// on the output from the result register. The
// tick state (commands, blink and status timers, rolling counter) is updated in
// the same cycle the input register hands its tick to the result register, so a
// stalled output stops intake only once both registers are full. Configuration
// registers may be written only while no tick is in flight.
module turn_lamp_arbiter_with_status
	import tla_pkg::*;
(
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cfg_wen,
	input  wire [1:0]             cfg_index,
	input  wire [CFG_W-1:0]       cfg_wdata,
	input  wire                   s_axis_tvalid,
	output logic                  s_axis_tready,
	// [0] click, [1] frame_valid, [12:2] frame_id, [20:13] frame_byte,
	// [21] slot_free, [23:22] zero
	input  wire [IN_TDATA_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  wire                   m_axis_tready,
	// [0] turn_lamp_on, [1] pos_lamp_on, [3:2] active_lamp, [4] status_sent,
	// [9:5] status_byte0, [13:10] status_byte1, [15:14] zero
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_nxt;
	item_t   item_s1;
	logic    valid_s1;
	result_t result_s2;
	result_t result_nxt;
	logic    valid_s2;
	logic    adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_id   <= FRAME_ID_RST;
			cfg_q.blink_half <= BLINK_HALF_RST;
			cfg_q.status_per <= STATUS_PER_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_FRAME_ID:   cfg_q.frame_id   <= cfg_wdata;
				REG_BLINK_HALF: cfg_q.blink_half <= cfg_wdata[9:0];
				REG_STATUS_PER: cfg_q.status_per <= cfg_wdata[9:0];
				default: ;
			endcase
		end
	end

	// result register frees when empty or being taken
	assign adv_s1        = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= item_t'(s_axis_tdata[$bits(item_t)-1:0]);
		end
	end

	tla_core u_core (
		.item   (item_s1),
		.st     (state_q),
		.cfg    (cfg_q),
		.st_nxt (state_nxt),
		.res    (result_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				state_q <= state_nxt;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_s2 <= result_nxt;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, result_s2};

	// A lit turn lamp means the turn lamp owns the output
	a_turn_owner: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.turn_lamp_on) |-> (result_s2.active_lamp == LAMP_TURN))
		else $error("turn lamp lit without turn priority");

	// Position lamp is forced off while the turn lamp has priority
	a_pos_forced: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.pos_lamp_on) |-> (result_s2.active_lamp == LAMP_POS))
		else $error("position lamp lit against arbitration");

	// Status bytes stay clear when no frame goes out
	a_status_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !result_s2.status_sent)
			|-> (result_s2.status_byte0 == 5'd0 && result_s2.status_byte1 == 4'd0))
		else $error("status bytes set without a status frame");

	// Rolling counter moves only with a sent status frame
	a_roll_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(adv_s1 && result_nxt.status_sent) |=> $stable(state_q.rolling_count))
		else $error("rolling counter moved without a status frame");

endmodule

`default_nettype wire
